>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the transcoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CHK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// shared types and constants of the utf-8 to utf-16 converter
// ----------------------------------------------------------------------------
package u2u_pkg;

   // default widths handed to the top level parameters
   localparam int LENGTH_WIDTH_DEF   = 16;
   localparam int CAPACITY_WIDTH_DEF = 16;

   // fixed field widths
   localparam int UNIT_W      = 16;
   localparam int WBYTES_W    = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int RSP_DATA_W  = 40;   // unit, run_last, status, written bytes, padded

   // byte classes
   localparam logic [7:0] LEAD_BAD_MIN = 8'hF5;
   localparam logic [7:0] LEAD_FOUR    = 8'hF0;
   localparam logic [7:0] LEAD_THREE   = 8'hE0;
   localparam logic [7:0] LEAD_TWO_MIN = 8'hC2;
   localparam logic [7:0] ASCII_END    = 8'h80;
   localparam logic [1:0] TRAIL_TAG    = 2'b10;   // top bits under mask 0xc0

   // code point limits
   localparam logic [15:0] REPLACEMENT = 16'hFFFD;
   localparam logic [20:0] CODE_MAX    = 21'h10FFFF;
   localparam logic [20:0] SURR_FIRST  = 21'h00D800;
   localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
   localparam logic [20:0] TWO_MIN     = 21'h000800;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;

   localparam logic [WBYTES_W-1:0] BYTES_MAX = 17'h1FFFF;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAPACITY   = 2'd0,
      CSR_COUNT_ONLY = 2'd1
   } csr_index_type;

   // stream status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNMAPPED  = 2'd1,
      STATUS_TOO_SMALL = 2'd2
   } status_type;

   // decoder state between bytes
   typedef struct packed {
      logic [20:0] acc;
      logic [1:0]  trail_need;
      logic [1:0]  trail_got;
      logic        skip;
   } dec_state_type;

   // up to three candidate words made by one byte
   typedef struct packed {
      logic [2:0][UNIT_W-1:0] unit;
      logic [2:0]             bad;
      logic [1:0]             count;
   } cand_type;

   // result record loaded into the output stage
   typedef struct packed {
      logic [2:0][UNIT_W-1:0] unit;
      logic [1:0]             last_idx;
      logic                   summary;
      logic                   stream_end;
      status_type             status;
      logic [WBYTES_W-1:0]    wbytes;
   } res_type;

endpackage

>>> hdl/u2u_in_stage.sv
// ----------------------------------------------------------------------------
// u2u_in_stage
// input register: holds one source byte and its length tag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u2u_in_stage #(
   parameter int LENGTH_WIDTH = u2u_pkg::LENGTH_WIDTH_DEF,
   localparam int REQ_W = ((8 + LENGTH_WIDTH + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_W-1:0]        req_tdata,   // byte_in, bytes_left
   input  logic                    item_take,
   output logic                    item_valid,
   output logic [7:0]              item_byte,
   output logic [LENGTH_WIDTH-1:0] item_left
);

   logic                    valid_ff, valid_in;
   logic [7:0]              byte_ff, byte_in;
   logic [LENGTH_WIDTH-1:0] left_ff, left_in;
   logic                    accept;

   // room when empty or when the held byte leaves this cycle
   assign req_tready = !valid_ff || item_take;
   assign accept     = req_tvalid && req_tready;

   // next register values
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      left_in  = left_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_tdata[7:0];
         left_in  = req_tdata[8 +: LENGTH_WIDTH];
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      left_ff <= left_in;
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;
   assign item_left  = left_ff;

   // a held byte that is not taken stays put
   `ASSERT_NEXT(a_hold_byte, clock, reset, valid_ff && !item_take, valid_ff && $stable(byte_ff) && $stable(left_ff), "in stage lost a held byte")

endmodule

>>> hdl/u2u_decode.sv
// ----------------------------------------------------------------------------
// u2u_decode
// per-byte utf-8 decode step: candidate words and next decoder state
// ----------------------------------------------------------------------------
module u2u_decode #(
   parameter int LENGTH_WIDTH = u2u_pkg::LENGTH_WIDTH_DEF
) (
   input  u2u_pkg::dec_state_type  st,
   input  logic [7:0]              byte_val,
   input  logic [LENGTH_WIDTH-1:0] left,     // zero already mapped to one
   input  logic                    last,
   output u2u_pkg::cand_type       cand,
   output u2u_pkg::dec_state_type  st_next
);

   always_comb begin
      logic [1:0]  n;
      logic        as_lead;
      logic [20:0] acc;
      logic [1:0]  got;
      logic [20:0] ch;
      logic [20:0] supp;
      logic        bad_cp;
      logic [1:0]  need;

      cand    = '0;
      st_next = st;
      n       = 2'd0;
      as_lead = 1'b1;
      acc     = '0;
      got     = '0;
      ch      = '0;
      supp    = '0;
      bad_cp  = 1'b0;
      need    = '0;

      if (st.skip) begin
         // rest of a truncated buffer is dropped
         as_lead = 1'b0;
      end else if (st.trail_need != 2'd0) begin
         if (byte_val[7:6] == u2u_pkg::TRAIL_TAG) begin
            // continuation byte
            as_lead         = 1'b0;
            acc             = {st.acc[14:0], byte_val[5:0]};
            got             = st.trail_got + 2'd1;
            st_next.acc       = acc;
            st_next.trail_got = got;
            if (got >= st.trail_need) begin
               // sequence complete
               ch     = acc;
               bad_cp = (ch > u2u_pkg::CODE_MAX) ||
                        (ch >= u2u_pkg::SURR_FIRST && ch <= u2u_pkg::SURR_LAST) ||
                        (st.trail_need == 2'd2 && ch < u2u_pkg::TWO_MIN) ||
                        (st.trail_need == 2'd3 && ch < u2u_pkg::SUPP_BASE);
               if (bad_cp) begin
                  // one replacement per trail byte
                  for (int k = 0; k < 3; k++) begin
                     if (2'(k) < st.trail_need) begin
                        cand.unit[n] = u2u_pkg::REPLACEMENT;
                        cand.bad[n]  = 1'b1;
                        n = n + 2'd1;
                     end
                  end
               end else if (ch >= u2u_pkg::SUPP_BASE) begin
                  // surrogate pair
                  supp         = ch - u2u_pkg::SUPP_BASE;
                  cand.unit[0] = u2u_pkg::HIGH_SURR + {6'd0, supp[19:10]};
                  cand.unit[1] = u2u_pkg::LOW_SURR + {6'd0, supp[9:0]};
                  n = 2'd2;
               end else begin
                  cand.unit[0] = ch[15:0];
                  n = 2'd1;
               end
               st_next.trail_need = 2'd0;
               st_next.trail_got  = 2'd0;
            end else if (last) begin
               // buffer ends inside the sequence
               cand.unit[0] = u2u_pkg::REPLACEMENT;
               cand.bad[0]  = 1'b1;
               n = 2'd1;
               st_next.trail_need = 2'd0;
               st_next.trail_got  = 2'd0;
            end
         end else begin
            // broken trail, then decode the byte as a lead
            cand.unit[0] = u2u_pkg::REPLACEMENT;
            cand.bad[0]  = 1'b1;
            n = 2'd1;
            st_next.trail_need = 2'd0;
            st_next.trail_got  = 2'd0;
         end
      end

      // lead byte
      if (as_lead) begin
         if (byte_val >= u2u_pkg::LEAD_BAD_MIN ||
             (byte_val >= u2u_pkg::ASCII_END && byte_val < u2u_pkg::LEAD_TWO_MIN)) begin
            cand.unit[n] = u2u_pkg::REPLACEMENT;
            cand.bad[n]  = 1'b1;
            n = n + 2'd1;
         end else if (byte_val < u2u_pkg::ASCII_END) begin
            cand.unit[n] = {8'd0, byte_val};
            n = n + 2'd1;
         end else begin
            if (byte_val >= u2u_pkg::LEAD_FOUR) begin
               need        = 2'd3;
               st_next.acc = {18'd0, byte_val[2:0]};
            end else if (byte_val >= u2u_pkg::LEAD_THREE) begin
               need        = 2'd2;
               st_next.acc = {17'd0, byte_val[3:0]};
            end else begin
               need        = 2'd1;
               st_next.acc = {16'd0, byte_val[4:0]};
            end
            if (left > LENGTH_WIDTH'(need)) begin
               st_next.trail_need = need;
               st_next.trail_got  = 2'd0;
            end else begin
               // trails would run past the buffer end
               cand.unit[n] = u2u_pkg::REPLACEMENT;
               cand.bad[n]  = 1'b1;
               n = n + 2'd1;
               st_next.acc  = '0;
               st_next.skip = 1'b1;
            end
         end
      end

      cand.count = n;
   end

endmodule

>>> hdl/u2u_out_stage.sv
// ----------------------------------------------------------------------------
// u2u_out_stage
// result register: holds up to three words of one byte and sends them in order
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u2u_out_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  u2u_pkg::res_type                 load_res,
   output logic                             out_free,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [u2u_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // unit, run_last, final_status,
                                                        // written_bytes
   output logic                             rsp_tuser,  // unit_valid
   output logic                             rsp_tlast   // stream_done
);

   logic             valid_ff, valid_in;
   logic [1:0]       idx_ff, idx_in;
   u2u_pkg::res_type res_ff, res_in;
   logic             at_last;
   logic             run_last;
   logic             done;
   logic [15:0]      unit_out;

   assign at_last  = (idx_ff == res_ff.last_idx);
   assign out_free = !valid_ff || (rsp_tready && at_last);

   // next register values
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
         res_in   = load_res;
      end else if (valid_ff && rsp_tready) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      res_ff <= res_in;
   end

   // word fields
   assign run_last = at_last;
   assign done     = res_ff.stream_end && at_last;
   assign unit_out = res_ff.summary ? 16'd0 : res_ff.unit[idx_ff];

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = !res_ff.summary;
   assign rsp_tlast  = done;
   assign rsp_tdata  = {
      4'd0,
      done ? res_ff.wbytes : {u2u_pkg::WBYTES_W{1'b0}},
      done ? res_ff.status : u2u_pkg::STATUS_OK,
      run_last,
      unit_out
   };

   `ASSERT_CHK(a_idx_range, clock, reset, !valid_ff || idx_ff <= res_ff.last_idx, "out stage index past last word")
   `ASSERT_CHK(a_summary_single, clock, reset, !(valid_ff && res_ff.summary) || res_ff.last_idx == 2'd0, "summary record with more than one word")

endmodule

>>> hdl/utf8_to_utf16_converter.sv
// Path: an accepted byte is held in the input stage register, decoded, then loaded into the
// output stage register, from which its first utf-16 word is offered on rsp.
// Throughput: one byte per cycle while each byte makes at most one word and rsp is not
// stalled; a byte that makes several words (surrogate pair, replacements) holds the input
// until the output stage, sending one word per cycle while rsp_tready is high, is done.
// Reset: synchronous, active high; clears decoder, counters, status and registers.
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter
// streaming utf-8 to utf-16 transcoder with room accounting and end-of-buffer summary
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_to_utf16_converter #(
   parameter int LENGTH_WIDTH   = u2u_pkg::LENGTH_WIDTH_DEF,
   parameter int CAPACITY_WIDTH = u2u_pkg::CAPACITY_WIDTH_DEF,
   localparam int REQ_W = ((8 + LENGTH_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // source bytes
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,   // byte_in, bytes_left
   // utf-16 words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [u2u_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // unit, run_last, final_status,
                                                          // written_bytes
   output logic                              rsp_tuser,   // unit_valid
   output logic                              rsp_tlast,   // stream_done
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [u2u_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [CAPACITY_WIDTH-1:0]         csr_data
);

   localparam int WB_W  = CAPACITY_WIDTH + 1;
   localparam int WB_XW = (WB_W > u2u_pkg::WBYTES_W) ? WB_W : u2u_pkg::WBYTES_W;

   // configuration registers
   logic [CAPACITY_WIDTH-1:0] cap_ff, cap_in;
   logic                      count_only_ff, count_only_in;

   // stream state
   logic                      fresh_ff, fresh_in;
   u2u_pkg::dec_state_type    dec_ff, dec_in;
   logic [CAPACITY_WIDTH-1:0] room_ff, room_in;
   logic [CAPACITY_WIDTH-1:0] units_ff, units_in;
   u2u_pkg::status_type       status_ff, status_in;

   // input stage
   logic                      item_valid;
   logic [7:0]                item_byte;
   logic [LENGTH_WIDTH-1:0]   item_left;
   logic                      item_take;

   // decode step
   logic [LENGTH_WIDTH-1:0]   left_eff;
   logic                      last;
   u2u_pkg::dec_state_type    dec_cur;
   u2u_pkg::dec_state_type    dec_next;
   u2u_pkg::cand_type         cand;

   // accounting
   logic [CAPACITY_WIDTH-1:0] room_cur;
   logic [CAPACITY_WIDTH-1:0] units_cur;
   u2u_pkg::status_type       status_cur;
   logic                      room_short;
   logic [1:0]                emit_n;
   logic [1:0]                add_n;
   logic [CAPACITY_WIDTH:0]   units_sum;
   logic [CAPACITY_WIDTH-1:0] units_new;
   logic [CAPACITY_WIDTH-1:0] room_new;
   u2u_pkg::status_type       status_new;
   logic                      dropped;
   logic [WB_XW-1:0]          wb_full;
   logic [u2u_pkg::WBYTES_W-1:0] wb_sat;
   logic                      need_out;
   logic                      out_free;
   u2u_pkg::res_type          res;

   // configuration port, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cap_in        = cap_ff;
      count_only_in = count_only_ff;
      if (csr_valid) begin
         unique case (csr_index)
            u2u_pkg::CSR_CAPACITY:   cap_in        = csr_data;
            u2u_pkg::CSR_COUNT_ONLY: count_only_in = csr_data[0];
            default: ;
         endcase
      end
   end

   u2u_in_stage #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .item_left  (item_left)
   );

   // a zero length tag counts as the last byte
   assign left_eff = (item_left == '0) ? LENGTH_WIDTH'(1) : item_left;
   assign last     = (left_eff == LENGTH_WIDTH'(1));

   // first byte of a stream starts from a clean state
   assign dec_cur    = fresh_ff ? '0 : dec_ff;
   assign room_cur   = fresh_ff ? cap_ff : room_ff;
   assign units_cur  = fresh_ff ? '0 : units_ff;
   assign status_cur = fresh_ff ? u2u_pkg::STATUS_OK : status_ff;

   u2u_decode #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) decode (
      .st       (dec_cur),
      .byte_val (item_byte),
      .left     (left_eff),
      .last     (last),
      .cand     (cand),
      .st_next  (dec_next)
   );

   // words that fit go out, the rest are dropped; in count-only mode none go out, all are counted
   assign room_short = (room_cur < CAPACITY_WIDTH'(cand.count));
   assign emit_n     = count_only_ff ? 2'd0 : (room_short ? room_cur[1:0] : cand.count);
   assign dropped    = !count_only_ff && room_short;
   assign add_n      = count_only_ff ? cand.count : emit_n;
   assign room_new   = room_cur - CAPACITY_WIDTH'(emit_n);

   // saturating word count
   assign units_sum  = {1'b0, units_cur} + (CAPACITY_WIDTH + 1)'(add_n);
   assign units_new  = units_sum[CAPACITY_WIDTH] ? {CAPACITY_WIDTH{1'b1}}
                                                 : units_sum[CAPACITY_WIDTH-1:0];

   // last status written wins; drops come after any replacement
   always_comb begin
      if (dropped) begin
         status_new = u2u_pkg::STATUS_TOO_SMALL;
      end else if (cand.bad != 3'd0) begin
         status_new = u2u_pkg::STATUS_UNMAPPED;
      end else begin
         status_new = status_cur;
      end
   end

   // output byte count, saturating
   assign wb_full = WB_XW'({units_new, 1'b0});
   assign wb_sat  = (wb_full > WB_XW'(u2u_pkg::BYTES_MAX)) ? u2u_pkg::BYTES_MAX
                                                           : wb_full[u2u_pkg::WBYTES_W-1:0];

   // result record
   always_comb begin
      res            = '0;
      res.unit       = cand.unit;
      res.summary    = (emit_n == 2'd0);
      res.last_idx   = (emit_n == 2'd0) ? 2'd0 : emit_n - 2'd1;
      res.stream_end = last;
      res.status     = status_new;
      res.wbytes     = wb_sat;
   end

   assign need_out  = (emit_n != 2'd0) || last;
   assign item_take = item_valid && (!need_out || out_free);

   u2u_out_stage out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (item_take && need_out),
      .load_res   (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // state update on each decoded byte
   always_comb begin
      fresh_in  = fresh_ff;
      dec_in    = dec_ff;
      room_in   = room_ff;
      units_in  = units_ff;
      status_in = status_ff;
      if (item_take) begin
         fresh_in  = last;
         dec_in    = dec_next;
         room_in   = room_new;
         units_in  = units_new;
         status_in = status_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= '0;
         count_only_ff <= 1'b0;
         fresh_ff      <= 1'b1;
         dec_ff        <= '0;
         room_ff       <= '0;
         units_ff      <= '0;
         status_ff     <= u2u_pkg::STATUS_OK;
      end else begin
         cap_ff        <= cap_in;
         count_only_ff <= count_only_in;
         fresh_ff      <= fresh_in;
         dec_ff        <= dec_in;
         room_ff       <= room_in;
         units_ff      <= units_in;
         status_ff     <= status_in;
      end
   end

   // a too-small status means the room ran out in this stream
   `ASSERT_CHK(a_full_room, clock, reset, fresh_ff || status_ff != u2u_pkg::STATUS_TOO_SMALL || room_ff == '0, "too-small status with room left")

endmodule

>>> sim/utf8_to_utf16_converter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter_test
// self-checking bench for the utf-8 to utf-16 converter: source buffers of
// well-formed and broken utf-8 go in under random back pressure on both
// sides, and each utf-16 word out is checked against a transcoder kept
// inside the scoreboard, over several capacity and count-only settings
// ----------------------------------------------------------------------------
module utf8_to_utf16_converter_test;

   localparam int REQ_W      = ((8 + u2u_pkg::LENGTH_WIDTH_DEF + 7) / 8) * 8;
   localparam int DRAIN_PAD  = 12;
   localparam int CYCLE_CAP  = 400000;
   localparam int CMP_W      = u2u_pkg::WBYTES_W;

   // unused register slots, writes there must be ignored
   localparam logic [u2u_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [u2u_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   // one expected utf-16 word with its side fields
   typedef struct {
      logic [u2u_pkg::UNIT_W-1:0]   unit;
      logic                         unit_valid;
      logic                         run_last;
      logic                         stream_done;
      logic [1:0]                   status;
      logic [u2u_pkg::WBYTES_W-1:0] wbytes;
   } utf16_word_type;

   // transcoder state and the words it still owes the bench
   class utf16_scoreboard;
      logic [15:0]                capacity;
      logic                       count_only;
      logic [20:0]                acc;
      logic [1:0]                 trail_need;
      logic [1:0]                 trail_got;
      logic                       skip;
      logic [15:0]                room;
      logic [15:0]                units;
      u2u_pkg::status_type        status;
      logic                       fresh;
      logic [u2u_pkg::UNIT_W-1:0] made[$];
      utf16_word_type             expected_words[$];
      int                         errors;

      function new();
         capacity   = '0;
         count_only = 1'b0;
         acc        = '0;
         trail_need = '0;
         trail_got  = '0;
         skip       = 1'b0;
         room       = '0;
         units      = '0;
         status     = u2u_pkg::STATUS_OK;
         fresh      = 1'b1;
         errors     = 0;
      endfunction

      function void write_reg(logic [u2u_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] value);
         case (idx)
            u2u_pkg::CSR_CAPACITY:   capacity = value;
            u2u_pkg::CSR_COUNT_ONLY: count_only = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // one unit into the destination, or only into the count
      function void put_unit(logic [u2u_pkg::UNIT_W-1:0] u);
         if (count_only) begin
            if (units != 16'hFFFF) units++;
         end else if (room != 0) begin
            room--;
            if (units != 16'hFFFF) units++;
            made.push_back(u);
         end else begin
            status = u2u_pkg::STATUS_TOO_SMALL;
         end
      endfunction

      // complete code point: range checks, then one unit or a pair
      function void finish_seq();
         logic [20:0] ch;
         logic [20:0] off;
         ch = acc;
         if (ch > u2u_pkg::CODE_MAX ||
             (ch >= u2u_pkg::SURR_FIRST && ch <= u2u_pkg::SURR_LAST) ||
             (trail_need == 2 && ch < u2u_pkg::TWO_MIN) ||
             (trail_need == 3 && ch < u2u_pkg::SUPP_BASE)) begin
            status = u2u_pkg::STATUS_UNMAPPED;
            for (int k = 0; k < trail_need; k++) put_unit(u2u_pkg::REPLACEMENT);
         end else if (ch >= u2u_pkg::SUPP_BASE) begin
            off = ch - u2u_pkg::SUPP_BASE;
            put_unit(u2u_pkg::HIGH_SURR + {6'd0, off[19:10]});
            put_unit(u2u_pkg::LOW_SURR + {6'd0, off[9:0]});
         end else begin
            put_unit(ch[15:0]);
         end
      endfunction

      function void take_lead(logic [7:0] b, int left);
         logic [1:0] t;
         if (b >= u2u_pkg::LEAD_BAD_MIN ||
             (b >= u2u_pkg::ASCII_END && b < u2u_pkg::LEAD_TWO_MIN)) begin
            status = u2u_pkg::STATUS_UNMAPPED;
            put_unit(u2u_pkg::REPLACEMENT);
            return;
         end
         if (b < u2u_pkg::ASCII_END) begin
            put_unit({8'h00, b});
            return;
         end
         if (b >= u2u_pkg::LEAD_FOUR) begin
            t   = 2'd3;
            acc = {18'd0, b[2:0]};
         end else if (b >= u2u_pkg::LEAD_THREE) begin
            t   = 2'd2;
            acc = {17'd0, b[3:0]};
         end else begin
            t   = 2'd1;
            acc = {16'd0, b[4:0]};
         end
         if (left - 1 >= int'(t)) begin
            trail_need = t;
            trail_got  = '0;
         end else begin
            // sequence runs past the buffer end, drop the rest
            status = u2u_pkg::STATUS_UNMAPPED;
            put_unit(u2u_pkg::REPLACEMENT);
            acc  = '0;
            skip = 1'b1;
         end
      endfunction

      // accepted source byte: work out the words it causes
      function void note_byte(logic [7:0] b, logic [15:0] tag);
         int             left;
         logic           last;
         logic           as_lead;
         logic           done;
         int             n;
         utf16_word_type w;
         left = int'(tag);
         if (left == 0) left = 1;
         last = (left == 1);
         if (fresh) begin
            room       = capacity;
            units      = '0;
            status     = u2u_pkg::STATUS_OK;
            acc        = '0;
            trail_need = '0;
            trail_got  = '0;
            skip       = 1'b0;
            fresh      = 1'b0;
         end
         made.delete();
         if (!skip) begin
            as_lead = 1'b1;
            if (trail_need != 0) begin
               if (b[7:6] == u2u_pkg::TRAIL_TAG) begin
                  as_lead = 1'b0;
                  acc     = {acc[14:0], b[5:0]};
                  trail_got++;
                  if (trail_got >= trail_need) begin
                     finish_seq();
                     trail_need = '0;
                     trail_got  = '0;
                  end else if (last) begin
                     // buffer ends inside the sequence
                     status = u2u_pkg::STATUS_UNMAPPED;
                     put_unit(u2u_pkg::REPLACEMENT);
                     trail_need = '0;
                     trail_got  = '0;
                  end
               end else begin
                  // broken trail, byte is retried as a lead
                  status = u2u_pkg::STATUS_UNMAPPED;
                  put_unit(u2u_pkg::REPLACEMENT);
                  trail_need = '0;
                  trail_got  = '0;
               end
            end
            if (as_lead) take_lead(b, left);
         end
         n = made.size();
         if (last && n == 0) n = 1;
         for (int k = 0; k < n; k++) begin
            done          = last && (k == n - 1);
            w.unit        = (k < made.size()) ? made[k] : '0;
            w.unit_valid  = (k < made.size());
            w.run_last    = (k == n - 1);
            w.stream_done = done;
            w.status      = done ? status : u2u_pkg::STATUS_OK;
            w.wbytes      = done ? {units, 1'b0} : '0;
            expected_words.push_back(w);
         end
         if (last) fresh = 1'b1;
      endfunction

      function void cmp(string name, logic [CMP_W-1:0] exp, logic [CMP_W-1:0] act);
         if (act !== exp) begin
            $error("%s: expected %0h actual %0h", name, exp, act);
            errors++;
         end
      endfunction

      // accepted utf-16 word against the oldest expectation
      function void check_word(logic [u2u_pkg::RSP_DATA_W-1:0] data, logic user, logic last);
         utf16_word_type w;
         if (expected_words.size() == 0) begin
            $error("word %h arrived with no expectation waiting", data);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         cmp("unit", CMP_W'(w.unit), CMP_W'(data[15:0]));
         cmp("unit_valid", CMP_W'(w.unit_valid), CMP_W'(user));
         cmp("run_last", CMP_W'(w.run_last), CMP_W'(data[16]));
         cmp("stream_done", CMP_W'(w.stream_done), CMP_W'(last));
         cmp("final_status", CMP_W'(w.status), CMP_W'(data[18:17]));
         cmp("written_bytes", w.wbytes, data[35:19]);
      endfunction
   endclass

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [REQ_W-1:0]                    req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [u2u_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tlast;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [u2u_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [15:0]                         csr_data = '0;

   utf16_scoreboard sb = new();
   int              req_idle_pct = 35;
   int              rsp_idle_pct = 35;
   int              sent_items = 0;
   int              cycle_count = 0;
   logic [7:0]      src_q[$];

   utf8_to_utf16_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // source word monitor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_byte(req_tdata[7:0], req_tdata[23:8]);
   end

   // result sink with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic csr_write(logic [u2u_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one source word, valid stays up when words follow back to back
   task automatic send_byte(logic [7:0] b, logic [15:0] tag);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tag, b};
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // hold the source until every expected word has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   function automatic void encode(logic [20:0] c, int n);
      case (n)
         1: src_q.push_back({1'b0, c[6:0]});
         2: begin
            src_q.push_back({3'b110, c[10:6]});
            src_q.push_back({2'b10, c[5:0]});
         end
         3: begin
            src_q.push_back({4'b1110, c[15:12]});
            src_q.push_back({2'b10, c[11:6]});
            src_q.push_back({2'b10, c[5:0]});
         end
         default: begin
            src_q.push_back({5'b11110, c[20:18]});
            src_q.push_back({2'b10, c[17:12]});
            src_q.push_back({2'b10, c[11:6]});
            src_q.push_back({2'b10, c[5:0]});
         end
      endcase
   endfunction

   // one character, mostly well formed, sometimes broken
   task automatic add_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30)
         encode(21'($urandom_range(0, 127)), 1);
      else if (pick < 50)
         encode(21'($urandom_range(128, 2047)), 2);
      else if (pick < 70)
         encode(21'($urandom_range(2048, 65535)), 3);
      else if (pick < 88)
         encode(21'($urandom_range(65536, 1114111)), 4);
      else begin
         case ($urandom_range(4))
            0: src_q.push_back(8'($urandom_range(0, 255)));
            1: encode(21'($urandom_range(0, 2047)), 3);
            2: encode(21'($urandom_range(0, 65535)), 4);
            3: encode(21'($urandom_range(1114112, 2097151)), 4);
            default: begin
               // sequence cut short, next character lands on a trail slot
               encode(21'($urandom_range(2048, 1114111)), int'($urandom_range(3, 4)));
               void'(src_q.pop_back());
            end
         endcase
      end
   endtask

   // a whole buffer with consistent remaining-byte tags
   task automatic send_stream(int len);
      src_q.delete();
      while (src_q.size() < len) add_char();
      while (src_q.size() > len) void'(src_q.pop_back());
      for (int i = 0; i < len; i++) send_byte(src_q[i], 16'(len - i));
   endtask

   // random bytes with arbitrary tags
   task automatic send_noise();
      int          n;
      logic [15:0] tag;
      n = $urandom_range(1, 4);
      repeat (n) begin
         tag = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 1))
                                        : 16'($urandom_range(0, 65535));
         send_byte(8'($urandom_range(0, 255)), tag);
      end
   endtask

   task automatic run_phase(logic [15:0] cap, logic co, int items, logic pause_mid);
      int          start;
      logic        paused;
      logic [14:0] junk;
      int          len;
      junk = 15'($urandom_range(0, 32767));
      csr_write(u2u_pkg::CSR_CAPACITY, cap);
      csr_write(u2u_pkg::CSR_COUNT_ONLY, {junk, co});
      csr_write($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                16'($urandom_range(0, 65535)));
      start  = sent_items;
      paused = 1'b0;
      while (sent_items - start < items) begin
         if ($urandom_range(99) < 10)
            send_noise();
         else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            send_stream(len);
         end
         if (pause_mid && !paused && sent_items - start >= items / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
      drain_results();
   endtask

   // directed buffers, tag in the upper bits
   localparam logic [REQ_W-1:0] DIRECTED [23] = '{
      // ascii extremes, top bad lead
      {16'd3, 8'h00}, {16'd2, 8'h7F}, {16'd1, 8'hFF},
      // bottom bad lead, smallest two-byte form
      {16'd3, 8'hC1}, {16'd2, 8'hC2}, {16'd1, 8'h80},
      // highest code point as a surrogate pair
      {16'd4, 8'hF4}, {16'd3, 8'h8F}, {16'd2, 8'hBF}, {16'd1, 8'hBF},
      // overlong three-byte form
      {16'd3, 8'hE0}, {16'd2, 8'h80}, {16'd1, 8'h80},
      // broken trail retried as ascii
      {16'd2, 8'hC3}, {16'd1, 8'h41},
      // lead running past the buffer end
      {16'd2, 8'hE2}, {16'd1, 8'h82},
      // encoded surrogate
      {16'd3, 8'hED}, {16'd2, 8'hA0}, {16'd1, 8'h80},
      // zero tag closes the buffer
      {16'd0, 8'h41},
      // buffer tagged closed inside a sequence
      {16'd3, 8'hE2}, {16'd1, 8'h82}
   };

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(u2u_pkg::CSR_CAPACITY, 16'hFFFF);
      csr_write(u2u_pkg::CSR_COUNT_ONLY, 16'h0000);
      foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][23:8]);
      drain_results();

      // no room, one unit of room, a few units
      run_phase(16'h0000, 1'b0, 50, 1'b0);
      run_phase(16'h0001, 1'b0, 50, 1'b0);
      run_phase(16'($urandom_range(2, 6)), 1'b0, 60, 1'b1);
      // counting only
      run_phase(16'hFFFF, 1'b1, 50, 1'b0);
      run_phase(16'($urandom_range(0, 65535)), 1'b1, 40, 1'b0);
      // full rate on both sides
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_phase(16'hFFFF, 1'b0, 80, 1'b0);
      req_idle_pct = 35;
      rsp_idle_pct = 35;
      run_phase(16'($urandom_range(0, 65535)), 1'b0, 70, 1'b0);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (sb.pending() != 0)
            $error("%0d expected words never arrived", sb.pending());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
